FILE: hw/rtl/hprr_pkg.sv
// Shared types and constants for the Hall pulse rotation rate block.
package hprr_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int INDEX_BITS   = 32;
    localparam int CEN_BITS     = INDEX_BITS + 1;
    localparam int PER_BITS     = 33;
    localparam int MID_BITS     = 34;
    localparam int FREQ_BITS    = 34;
    localparam int RATE_BITS    = 27;
    localparam int Q8_SHIFT     = 9;
    localparam int DIVD_BITS    = RATE_BITS + Q8_SHIFT;
    localparam int REM_BITS     = CEN_BITS + 1;
    localparam int CNT_BITS     = 6;
    localparam int IN_TDATA_BITS  = 16;
    localparam int OUT_FIELD_BITS = FREQ_BITS + MID_BITS + PER_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = RATE_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TWO_MAG   = 2'd2;

    localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_RST = -16'sd200;
    localparam logic [RATE_BITS-1:0]          RATE_RST      = 27'd1000000;
    localparam logic [FREQ_BITS-1:0]          FREQ_MAX      = {FREQ_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_PERIOD,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

FILE: hw/rtl/hall_pulse_rotation_rate_core.sv
// Hall pulse tachometer: pulse detection, centre tracking and rate divider.
//
// Usage: one signed 16-bit converter sample per input word on the s-side
// stream (tdata[15:0]). Samples strictly below the threshold register form
// a pulse; when a pulse ends and an earlier centre is known, one word leaves
// on the m-side stream holding frequency (Q8 Hz), midpoint time in quarter
// samples and centre-to-centre period in half samples.
// Flow: a sample that does not end a pulse leaves s-side tready high. A sample
// that ends a pulse goes through the centre add and, when an earlier centre
// is known, the period/midpoint add; for a non-zero period the restoring
// divider then works one quotient bit per cycle through one shared
// subtractor, and the output register is loaded last. s-side tready stays
// low for the whole of that work, so no new sample is taken until it ends.
// The output register holds a finished word while the receiver stalls; the
// block keeps accepting samples, and only a second result waits in the final
// step until the held word is taken.
// Reset (synchronous, active low) clears the sample counter, pulse tracking
// and output valid, and loads the register defaults: threshold -200,
// 1000000 Hz, single magnet. Configuration is written through i_cfg_we.
module hall_pulse_rotation_rate_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [hprr_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [hprr_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [hprr_pkg::IN_TDATA_BITS-1:0]     s_tdata,   // [15:0] adc_sample
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [33:0] freq_hz_q8, [67:34] midpoint_quarter_samples,
    // [100:68] period_half_samples, [103:101] zero
    output logic [hprr_pkg::OUT_TDATA_BITS-1:0]    m_tdata
);

    hprr_pkg::t_state r_state, n_state;

    logic signed [hprr_pkg::SAMPLE_BITS-1:0] r_threshold;
    logic [hprr_pkg::RATE_BITS-1:0]          r_rate;
    logic                                    r_two_mag;

    logic [hprr_pkg::INDEX_BITS-1:0] r_count;
    logic                            r_inside;
    logic [hprr_pkg::INDEX_BITS-1:0] r_first;
    logic [hprr_pkg::INDEX_BITS-1:0] r_last;
    logic [hprr_pkg::CEN_BITS-1:0]   r_centre;
    logic [hprr_pkg::CEN_BITS-1:0]   r_last_centre;
    logic                            r_have_centre;
    logic [hprr_pkg::PER_BITS-1:0]   r_period;
    logic [hprr_pkg::MID_BITS-1:0]   r_mid;
    logic [hprr_pkg::DIVD_BITS-1:0]  r_quo;
    logic [hprr_pkg::REM_BITS-1:0]   r_rem;
    logic [hprr_pkg::CNT_BITS-1:0]   r_cnt;
    logic                            r_zero_per;

    logic                            r_out_valid;
    logic [hprr_pkg::FREQ_BITS-1:0]  r_out_freq;
    logic [hprr_pkg::MID_BITS-1:0]   r_out_mid;
    logic [hprr_pkg::PER_BITS-1:0]   r_out_per;

    logic                            in_accept;
    logic                            below;
    logic                            pulse_end;
    logic                            out_free;
    logic [hprr_pkg::REM_BITS-1:0]   rem_shift;
    logic [hprr_pkg::REM_BITS:0]     trial;
    logic [hprr_pkg::DIVD_BITS-1:0]  quo_adj;
    logic [hprr_pkg::FREQ_BITS-1:0]  freq_final;
    logic [hprr_pkg::CEN_BITS-1:0]   period_full;

    assign s_tready  = (r_state == hprr_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign below     = $signed(s_tdata[hprr_pkg::SAMPLE_BITS-1:0]) < r_threshold;
    assign pulse_end = in_accept && !below && r_inside;
    assign out_free  = !r_out_valid || m_tready;

    // One subtractor serves every quotient bit.
    assign rem_shift = {r_rem[hprr_pkg::REM_BITS-2:0], r_quo[hprr_pkg::DIVD_BITS-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, r_period};
    assign quo_adj   = r_two_mag ? (r_quo >> 1) : r_quo;
    assign freq_final = r_zero_per ? hprr_pkg::FREQ_MAX :
        ((quo_adj[hprr_pkg::DIVD_BITS-1:hprr_pkg::FREQ_BITS] != '0) ? hprr_pkg::FREQ_MAX
                                              : quo_adj[hprr_pkg::FREQ_BITS-1:0]);
    assign period_full = r_centre - r_last_centre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hprr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hprr_pkg::ST_IDLE: begin
                if (pulse_end) begin
                    n_state = hprr_pkg::ST_CENTRE;
                end
            end
            hprr_pkg::ST_CENTRE: begin
                n_state = r_have_centre ? hprr_pkg::ST_PERIOD : hprr_pkg::ST_IDLE;
            end
            hprr_pkg::ST_PERIOD: begin
                n_state = (period_full == '0) ? hprr_pkg::ST_DONE : hprr_pkg::ST_DIV;
            end
            hprr_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = hprr_pkg::ST_DONE;
                end
            end
            hprr_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = hprr_pkg::ST_IDLE;
                end
            end
            default: n_state = hprr_pkg::ST_IDLE;
        endcase
    end

    // Configuration and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= hprr_pkg::THRESHOLD_RST;
            r_rate        <= hprr_pkg::RATE_RST;
            r_two_mag     <= 1'b0;
            r_count       <= '0;
            r_inside      <= 1'b0;
            r_first       <= '0;
            r_last_centre <= '0;
            r_have_centre <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hprr_pkg::CFG_THRESHOLD:
                        r_threshold <= i_cfg_data[hprr_pkg::SAMPLE_BITS-1:0];
                    hprr_pkg::CFG_RATE:    r_rate    <= i_cfg_data;
                    hprr_pkg::CFG_TWO_MAG: r_two_mag <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_count <= r_count + 1'b1;
                if (below) begin
                    if (!r_inside) begin
                        r_inside <= 1'b1;
                        r_first  <= r_count;
                    end
                end else begin
                    r_inside <= 1'b0;
                end
            end
            if (r_state == hprr_pkg::ST_CENTRE) begin
                r_last_centre <= r_centre;
                r_have_centre <= 1'b1;
            end
            if (r_state == hprr_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (pulse_end) begin
            r_last <= r_count - 1'b1;
        end
        if (r_state == hprr_pkg::ST_CENTRE) begin
            r_centre <= {1'b0, r_first} + {1'b0, r_last};
        end
        if (r_state == hprr_pkg::ST_PERIOD) begin
            r_period   <= period_full;
            r_mid      <= {1'b0, r_centre} + {1'b0, r_last_centre};
            r_zero_per <= (period_full == '0);
            r_quo      <= {r_rate, {hprr_pkg::Q8_SHIFT{1'b0}}};
            r_rem      <= '0;
            r_cnt      <= hprr_pkg::CNT_BITS'(hprr_pkg::DIVD_BITS - 1);
        end
        if (r_state == hprr_pkg::ST_DIV) begin
            r_cnt <= r_cnt - 1'b1;
            if (!trial[hprr_pkg::REM_BITS]) begin
                r_rem <= trial[hprr_pkg::REM_BITS-1:0];
                r_quo <= {r_quo[hprr_pkg::DIVD_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_shift;
                r_quo <= {r_quo[hprr_pkg::DIVD_BITS-2:0], 1'b0};
            end
        end
        if (r_state == hprr_pkg::ST_DONE && out_free) begin
            r_out_freq <= freq_final;
            r_out_mid  <= r_mid;
            r_out_per  <= r_period;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(hprr_pkg::OUT_TDATA_BITS - hprr_pkg::OUT_FIELD_BITS){1'b0}},
                       r_out_per, r_out_mid, r_out_freq};

endmodule

FILE: hw/rtl/hprr_checker.sv
// Port-level checker for the Hall pulse rotation rate block, with its bind.
module hprr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [hprr_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    // A new result comes from the final step, never straight from an accepted word.
    a_no_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared right after an accepted word");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[hprr_pkg::OUT_TDATA_BITS-1:hprr_pkg::OUT_FIELD_BITS] == '0))
        else $error("padding bits not zero");

    // A zero period must report the saturated frequency.
    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tdata[hprr_pkg::OUT_FIELD_BITS-1:
                              hprr_pkg::FREQ_BITS+hprr_pkg::MID_BITS] == '0))
        |-> (m_tdata[hprr_pkg::FREQ_BITS-1:0] == hprr_pkg::FREQ_MAX))
        else $error("zero period without saturated frequency");

endmodule

bind hall_pulse_rotation_rate_core hprr_checker u_hprr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
